### rtl/core/sample_voice_mixer_defines.svh
`ifndef SAMPLE_VOICE_MIXER_DEFINES_SVH
`define SAMPLE_VOICE_MIXER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SVM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/svm_pkg.sv
`default_nettype none

package svm_pkg;

	localparam int SAMPLE_WORDS = 65536;
	localparam int ADDR_W       = 16;
	localparam int DATA_W       = 16;
	localparam int LEN_W        = 17;
	localparam int GAIN_W       = 15;
	localparam int BUSY_W       = 8;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd28000;
	localparam logic signed [DATA_W-1:0] MIX_MAX = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] MIX_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_RENDER = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_CLAIM,
		ST_RENDER,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic mem_wr;
		logic scan;
		logic claim;
		logic render;
		logic finish;
	} svm_cmd_t;

endpackage

`default_nettype wire

### rtl/core/svm_ctrl.sv
`default_nettype none

module svm_ctrl #(
	parameter int VOICE_COUNT = 8,
	parameter int VIDX_W      = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        func,
	output svm_pkg::svm_cmd_t      cmd,
	output logic [VIDX_W-1:0]      idx,
	output logic                   busy
);

	svm_pkg::state_t state_q, state_d;
	logic [VIDX_W-1:0] idx_q, idx_d;
	logic last;

	assign last = (idx_q == VIDX_W'(VOICE_COUNT - 1));
	assign idx  = idx_q;
	assign busy = (state_q != svm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svm_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		unique case (state_q)
			svm_pkg::ST_IDLE: begin
				idx_d = '0;
				if (start) begin
					cmd.capture = 1'b1;
					unique case (func)
						svm_pkg::FUNC_LOAD:   state_d = svm_pkg::ST_LOAD;
						svm_pkg::FUNC_START:  state_d = svm_pkg::ST_SCAN;
						svm_pkg::FUNC_RENDER: state_d = svm_pkg::ST_RENDER;
						default:              state_d = svm_pkg::ST_IDLE;
					endcase
				end
			end
			svm_pkg::ST_LOAD: begin
				cmd.mem_wr = 1'b1;
				state_d    = svm_pkg::ST_IDLE;
			end
			svm_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				idx_d    = idx_q + 1'b1;
				if (last) begin
					state_d = svm_pkg::ST_CLAIM;
				end
			end
			svm_pkg::ST_CLAIM: begin
				cmd.claim = 1'b1;
				state_d   = svm_pkg::ST_IDLE;
			end
			svm_pkg::ST_RENDER: begin
				cmd.render = 1'b1;
				idx_d      = idx_q + 1'b1;
				if (last) begin
					state_d = svm_pkg::ST_DRAIN1;
				end
			end
			svm_pkg::ST_DRAIN1: state_d = svm_pkg::ST_DRAIN2;
			svm_pkg::ST_DRAIN2: state_d = svm_pkg::ST_DONE;
			svm_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = svm_pkg::ST_IDLE;
			end
			default: state_d = svm_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/svm_datapath.sv
`default_nettype none

module svm_datapath #(
	parameter int VOICE_COUNT = 8,
	parameter int VIDX_W      = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire svm_pkg::svm_cmd_t                   cmd,
	input  wire logic [VIDX_W-1:0]                   idx,
	input  wire logic [svm_pkg::ADDR_W-1:0]          load_addr,
	input  wire logic signed [svm_pkg::DATA_W-1:0]   load_data,
	input  wire logic [svm_pkg::ADDR_W-1:0]          start_addr,
	input  wire logic [svm_pkg::LEN_W-1:0]           frame_count,
	input  wire logic                                cfg_valid,
	input  wire logic [svm_pkg::GAIN_W-1:0]          cfg_data,
	output logic                                     done,
	output logic signed [svm_pkg::DATA_W-1:0]        mix_out,
	output logic [svm_pkg::BUSY_W-1:0]               voices_busy
);

	localparam int ACC_W = svm_pkg::DATA_W + $clog2(VOICE_COUNT) + 1;

	logic [svm_pkg::DATA_W-1:0] mem [svm_pkg::SAMPLE_WORDS];

	logic [svm_pkg::ADDR_W-1:0]        load_addr_q;
	logic [svm_pkg::DATA_W-1:0]        load_data_q;
	logic [svm_pkg::ADDR_W-1:0]        start_addr_q;
	logic [svm_pkg::LEN_W-1:0]         frame_count_q;
	logic [svm_pkg::GAIN_W-1:0]        gain_q;

	logic [VOICE_COUNT-1:0]            active_q;
	logic [svm_pkg::LEN_W-1:0]         pos_q  [VOICE_COUNT];
	logic [svm_pkg::ADDR_W-1:0]        base_q [VOICE_COUNT];
	logic [svm_pkg::LEN_W-1:0]         len_q  [VOICE_COUNT];
	logic [svm_pkg::GAIN_W-1:0]        amp_q  [VOICE_COUNT];

	logic                              found_q;
	logic [VIDX_W-1:0]                 pick_q;
	logic [svm_pkg::LEN_W-1:0]         best_q;

	logic [svm_pkg::ADDR_W-1:0]        rd_addr;
	logic signed [svm_pkg::DATA_W-1:0] rd_s1;
	logic [svm_pkg::GAIN_W-1:0]        amp_s1;
	logic                              valid_s1;
	logic signed [31:0]                prod_s2;
	logic                              valid_s2;
	logic signed [svm_pkg::DATA_W-1:0] term;
	logic signed [ACC_W-1:0]           acc_q;

	logic                              done_q;
	logic signed [svm_pkg::DATA_W-1:0] mix_q;
	logic [svm_pkg::BUSY_W-1:0]        busy_q;
	logic [svm_pkg::BUSY_W-1:0]        busy_vec;
	logic                              ended;

	// store address wraps at the store size
	assign rd_addr = base_q[idx] + pos_q[idx][svm_pkg::ADDR_W-1:0];
	assign ended   = (pos_q[idx] >= len_q[idx]);
	assign term    = prod_s2[30:15];

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[load_addr_q] <= load_data_q;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			load_addr_q   <= load_addr;
			load_data_q   <= load_data;
			start_addr_q  <= start_addr;
			frame_count_q <= frame_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= svm_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				pos_q[i] <= '0;
			end
		end else if (cmd.claim) begin
			active_q[pick_q] <= 1'b1;
			pos_q[pick_q]    <= '0;
		end else if (cmd.render && active_q[idx]) begin
			if (ended) begin
				active_q[idx] <= 1'b0;
			end else begin
				pos_q[idx] <= pos_q[idx] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			base_q[pick_q] <= start_addr_q;
			len_q[pick_q]  <= frame_count_q;
			amp_q[pick_q]  <= gain_q;
		end
	end

	// first free voice, else strictly furthest along, else voice 0
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= '0;
		end else if (cmd.scan && !found_q) begin
			if (!active_q[idx]) begin
				found_q <= 1'b1;
				pick_q  <= idx;
			end else if (pos_q[idx] > best_q) begin
				best_q <= pos_q[idx];
				pick_q <= idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.render && active_q[idx] && !ended;
			valid_s2 <= valid_s1;
			done_q   <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		amp_s1  <= amp_q[idx];
		prod_s2 <= rd_s1 * $signed({1'b0, amp_s1});
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(term);
		end
	end

	always_comb begin
		busy_vec = '0;
		for (int i = 0; i < svm_pkg::BUSY_W; i++) begin
			if (i < VOICE_COUNT) begin
				busy_vec[i] = active_q[i % VOICE_COUNT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			busy_q <= busy_vec;
			priority if (acc_q > ACC_W'(svm_pkg::MIX_MAX)) begin
				mix_q <= svm_pkg::MIX_MAX;
			end else if (acc_q < ACC_W'(svm_pkg::MIX_MIN)) begin
				mix_q <= svm_pkg::MIX_MIN;
			end else begin
				mix_q <= acc_q[svm_pkg::DATA_W-1:0];
			end
		end
	end

	assign done        = done_q;
	assign mix_out     = mix_q;
	assign voices_busy = busy_q;

endmodule

`default_nettype wire

### rtl/core/sample_voice_mixer.sv
// Load: accepted, then busy while the word is written. Start: busy while voices are
// scanned (one voice examined per cycle) and while the pick is claimed. Render: the
// done strobe follows states RENDER, DRAIN1, DRAIN2 and DONE, with one sample-store
// read per voice on a single read port. A new item is taken in the cycle the done strobe
// shows; results cannot be stalled. arst_n frees all voices, zeroes positions, sets
// gain to 28000; the sample store is not cleared.
`default_nettype none

module sample_voice_mixer #(
	parameter int VOICE_COUNT = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          func,
	input  wire logic [svm_pkg::ADDR_W-1:0]          load_addr,
	input  wire logic signed [svm_pkg::DATA_W-1:0]   load_data,
	input  wire logic [svm_pkg::ADDR_W-1:0]          start_addr,
	input  wire logic [svm_pkg::LEN_W-1:0]           frame_count,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [svm_pkg::GAIN_W-1:0]          cfg_data,
	output logic                                     done,
	output logic signed [svm_pkg::DATA_W-1:0]        mix_out,
	output logic [svm_pkg::BUSY_W-1:0]               voices_busy
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	svm_pkg::svm_cmd_t cmd;
	logic [VIDX_W-1:0] idx;

	assign cfg_ready = 1'b1;

	svm_ctrl #(
		.VOICE_COUNT(VOICE_COUNT),
		.VIDX_W     (VIDX_W)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.cmd   (cmd),
		.idx   (idx),
		.busy  (busy)
	);

	svm_datapath #(
		.VOICE_COUNT(VOICE_COUNT),
		.VIDX_W     (VIDX_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.load_addr  (load_addr),
		.load_data  (load_data),
		.start_addr (start_addr),
		.frame_count(frame_count),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.done       (done),
		.mix_out    (mix_out),
		.voices_busy(voices_busy)
	);

endmodule

`default_nettype wire

### rtl/core/svm_checker.sv
`default_nettype none
`include "sample_voice_mixer_defines.svh"

module svm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] func,
	input wire logic       done
);

	`SVM_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	`SVM_ASSERT_NEXT(a_accept_busy, start && !busy && (func == svm_pkg::FUNC_LOAD || func == svm_pkg::FUNC_START || func == svm_pkg::FUNC_RENDER), busy, "no busy after transfer")
	`SVM_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result right after transfer")
	`SVM_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

bind sample_voice_mixer svm_checker u_svm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.func  (func),
	.done  (done)
);

`default_nettype wire

### tb/tb_sample_voice_mixer.sv
`timescale 1ns / 1ps

module tb_sample_voice_mixer;

	localparam int VOICES = 8;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 24;

	typedef struct {
		logic signed [15:0] mix;
		logic [7:0]         busy;
	} frame_t;

	class voice_mix_tracker;
		logic signed [15:0] words [bit [15:0]];
		bit                 active [VOICES];
		bit [15:0]          base [VOICES];
		bit [16:0]          length [VOICES];
		bit [16:0]          pos [VOICES];
		bit [14:0]          amp [VOICES];
		bit [14:0]          gain;
		frame_t             frames_due [$];
		int                 errors;
		int                 frames;

		function new();
			gain = svm_pkg::GAIN_RESET;
			errors = 0;
			frames = 0;
			foreach (active[i]) begin
				active[i] = 1'b0;
				pos[i] = '0;
			end
		endfunction

		function void set_gain(bit [14:0] g);
			gain = g;
		endfunction

		function void claim_voice(bit [15:0] b, bit [16:0] n);
			int pick;
			bit [16:0] best;
			pick = -1;
			best = '0;
			for (int i = 0; i < VOICES; i++) begin
				if (!active[i]) begin
					pick = i;
					break;
				end
				if (pos[i] > best) begin
					best = pos[i];
					pick = i;
				end
			end
			if (pick < 0)
				pick = 0;
			active[pick] = 1'b1;
			base[pick] = b;
			length[pick] = n;
			pos[pick] = '0;
			amp[pick] = gain;
		endfunction

		function frame_t render_frame();
			frame_t f;
			int acc;
			int w;
			int p;
			bit [15:0] a;
			acc = 0;
			f.busy = '0;
			for (int v = 0; v < VOICES; v++) begin
				if (!active[v])
					continue;
				if (pos[v] >= length[v]) begin
					active[v] = 1'b0;
					continue;
				end
				a = base[v] + pos[v][15:0];
				w = words[a];
				pos[v] = pos[v] + 17'd1;
				p = w * int'(amp[v]);
				acc += p >>> 15;
			end
			if (acc > int'(svm_pkg::MIX_MAX))
				acc = int'(svm_pkg::MIX_MAX);
			if (acc < int'(svm_pkg::MIX_MIN))
				acc = int'(svm_pkg::MIX_MIN);
			f.mix = acc[15:0];
			for (int v = 0; v < VOICES; v++)
				f.busy[v] = active[v];
			return f;
		endfunction

		function void note_item(logic [1:0] fn, bit [15:0] la, logic signed [15:0] ld,
				bit [15:0] sa, bit [16:0] fc);
			case (fn)
				svm_pkg::FUNC_LOAD: words[la] = ld;
				svm_pkg::FUNC_START: claim_voice(sa, fc);
				svm_pkg::FUNC_RENDER: frames_due.push_back(render_frame());
				default: ;
			endcase
		endfunction

		// next render must not read a word that was never loaded
		function bit missing_word(output bit [15:0] a);
			a = '0;
			for (int v = 0; v < VOICES; v++) begin
				if (active[v] && pos[v] < length[v]) begin
					a = base[v] + pos[v][15:0];
					if (!words.exists(a))
						return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		task report(string what);
			$display("mismatch @%0t: %s", $realtime, what);
			errors++;
		endtask

		task check_frame(logic signed [15:0] m, logic [7:0] b);
			frame_t e;
			if (frames_due.size() == 0) begin
				report($sformatf("frame with nothing due: mix %0d busy %02h", m, b));
			end else begin
				e = frames_due.pop_front();
				frames++;
				if (m !== e.mix)
					report($sformatf("frame %0d mix_out %0d, want %0d", frames, m, e.mix));
				if (b !== e.busy)
					report($sformatf("frame %0d voices_busy %02h, want %02h", frames, b,
						e.busy));
			end
		endtask

		function int pending();
			return frames_due.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic [1:0]                        func = svm_pkg::FUNC_LOAD;
	logic [svm_pkg::ADDR_W-1:0]        load_addr = '0;
	logic signed [svm_pkg::DATA_W-1:0] load_data = '0;
	logic [svm_pkg::ADDR_W-1:0]        start_addr = '0;
	logic [svm_pkg::LEN_W-1:0]         frame_count = '0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [svm_pkg::GAIN_W-1:0]        cfg_data = '0;
	logic                              done;
	logic signed [svm_pkg::DATA_W-1:0] mix_out;
	logic [svm_pkg::BUSY_W-1:0]        voices_busy;

	voice_mix_tracker tracker = new();

	int n_items = 0;
	int n_loads = 0;
	int n_starts = 0;
	int n_renders = 0;
	int n_gains = 0;
	int burst_left = 0;

	sample_voice_mixer #(.VOICE_COUNT(VOICES)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.load_addr   (load_addr),
		.load_data   (load_data),
		.start_addr  (start_addr),
		.frame_count (frame_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.mix_out     (mix_out),
		.voices_busy (voices_busy)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_frame(mix_out, voices_busy);
	end

	// one transfer, then maybe a gap between bursts
	task send(logic [1:0] fn, bit [15:0] la, logic signed [15:0] ld, bit [15:0] sa,
			bit [16:0] fc);
		int gap;
		start <= 1'b1;
		func <= fn;
		load_addr <= la;
		load_data <= ld;
		start_addr <= sa;
		frame_count <= fc;
		do @(posedge clk); while (busy);
		tracker.note_item(fn, la, ld, sa, fc);
		case (fn)
			svm_pkg::FUNC_LOAD: n_loads++;
			svm_pkg::FUNC_START: n_starts++;
			svm_pkg::FUNC_RENDER: n_renders++;
			default: ;
		endcase
		if (fn != FUNC_UNUSED)
			n_items++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task item(logic [1:0] fn, bit [15:0] la, logic signed [15:0] ld, bit [15:0] sa,
			bit [16:0] fc);
		bit [15:0] a;
		if (fn == svm_pkg::FUNC_RENDER) begin
			while (tracker.missing_word(a))
				send(svm_pkg::FUNC_LOAD, a, 16'($urandom), 16'($urandom), 17'($urandom));
		end
		send(fn, la, ld, sa, fc);
	endtask

	task load_word(bit [15:0] a, logic signed [15:0] d);
		item(svm_pkg::FUNC_LOAD, a, d, 16'($urandom), 17'($urandom));
	endtask

	task launch_voice(bit [15:0] b, bit [16:0] n);
		item(svm_pkg::FUNC_START, 16'($urandom), 16'($urandom), b, n);
	endtask

	task render();
		item(svm_pkg::FUNC_RENDER, 16'($urandom), 16'($urandom), 16'($urandom),
			17'($urandom));
	endtask

	task settle();
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_gain(bit [14:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_gain(g);
		n_gains++;
	endtask

	task random_phase(int count);
		int goal;
		int r;
		int k;
		bit [15:0] b;
		bit [16:0] n;
		goal = n_items + count;
		while (n_items < goal) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				item(FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
					17'($urandom));
			end else if (r < 30) begin
				b = ($urandom_range(0, 1) == 0) ? 16'h4000 + 16'($urandom_range(0, 255))
					: 16'($urandom);
				load_word(b, 16'($urandom));
			end else if (r < 50) begin
				b = ($urandom_range(0, 9) < 6) ? 16'h4000 + 16'($urandom_range(0, 255))
					: 16'($urandom);
				k = $urandom_range(0, 99);
				if (k < 70)
					n = 17'($urandom_range(0, 24));
				else if (k < 85)
					n = 17'($urandom_range(25, 300));
				else if (k < 95)
					n = 17'($urandom);
				else
					n = (k == 95) ? 17'd0 : (k < 98) ? 17'd65536 : 17'h1FFFF;
				launch_voice(b, n);
			end else begin
				render();
			end
		end
	endtask

	initial begin
		bit [14:0] gains [5];
		gains = '{15'd32767, 15'd0, 15'd1, 15'($urandom), svm_pkg::GAIN_RESET};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		render();
		item(FUNC_UNUSED, 16'hFFFF, 16'sh7FFF, 16'hFFFF, 17'h1FFFF);
		load_word(16'hFFFF, 16'sh7FFF);
		load_word(16'h0000, 16'sh7FFF);
		load_word(16'h0001, 16'sh8000);
		load_word(16'h0002, 16'sh8000);
		for (int i = 0; i < VOICES; i++)
			launch_voice(16'h0001, 17'd1);
		render();
		// all voices busy: each start steals the next
		for (int i = 0; i < VOICES; i++)
			launch_voice(16'hFFFF, 17'd2);
		render();
		render();
		launch_voice(16'h0000, 17'd0);
		launch_voice(16'hFFFE, 17'h1FFFF);
		render();
		render();
		settle();

		foreach (gains[p]) begin
			write_gain(gains[p]);
			random_phase(280);
			settle();
		end

		$display("ran %0d items: %0d loads, %0d starts, %0d renders", n_items, n_loads,
			n_starts, n_renders);
		$display("checked %0d frames over %0d gain settings", tracker.frames, n_gains);
		if (tracker.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout, frames still due: %0d", tracker.pending());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
